// ===== rtl/rcsu_pkg.sv =====
`default_nettype none
package rcsu_pkg;

  // Width of a coordinate; sizes are one bit narrower and unsigned.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned SIZE_BITS  = COORD_BITS - 1;
  // Internal width: holds any edge or difference of edges exactly.
  localparam int unsigned EXT_BITS   = COORD_BITS + 3;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int unsigned NUM_PIECES = 4;

  // Operation codes of the func field.
  localparam logic [1:0] FUNC_INTERSECT = 2'd0;
  localparam logic [1:0] FUNC_UNITE     = 2'd1;
  localparam logic [1:0] FUNC_SUBTRACT  = 2'd2;
  localparam logic [1:0] FUNC_CONSTRAIN = 2'd3;

  typedef logic signed [EXT_BITS-1:0] ext_t;

  // What the back end has to build for a queued item.
  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_INTER,
    KIND_UNITE,
    KIND_CONSTR,
    KIND_PASS_A,
    KIND_PASS_B,
    KIND_SUB
  } kind_e;

  // Subtract pieces in the order they leave the block; also bit positions in the mask.
  typedef enum logic [1:0] {
    PIECE_TOP,
    PIECE_BOTTOM,
    PIECE_LEFT,
    PIECE_RIGHT
  } piece_e;

  typedef struct packed {
    kind_e                 kind;
    logic [NUM_PIECES-1:0] mask;
    logic                  ax_lt_bx;
    logic                  ay_lt_by;
    logic                  ar_gt_br;
    logic                  ab_gt_bb;
    ext_t                  ax;
    ext_t                  ay;
    ext_t                  aw;
    ext_t                  ah;
    ext_t                  ar;
    ext_t                  ab;
    ext_t                  bx;
    ext_t                  by;
    ext_t                  bw;
    ext_t                  bh;
    ext_t                  br;
    ext_t                  bb;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/rcsu_front.sv =====
`default_nettype none
module rcsu_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push_i,
  output logic                                      full_o,
  input  wire logic [1:0]                           func_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] a_x_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] a_y_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       a_w_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       a_h_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] b_x_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] b_y_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       b_w_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       b_h_i,
  output logic                                      q_push_o,
  input  wire logic                                 q_full_i,
  output rcsu_pkg::job_t                            q_job_o
);

  localparam int unsigned CoordExt = rcsu_pkg::EXT_BITS - rcsu_pkg::COORD_BITS;
  localparam int unsigned SizeExt  = rcsu_pkg::EXT_BITS - rcsu_pkg::SIZE_BITS;

  logic                                    valid_q, valid_d;
  logic                                    accept, advance, has_out;
  logic [1:0]                              func_q;
  logic signed [rcsu_pkg::COORD_BITS-1:0]  a_x_q, a_y_q, b_x_q, b_y_q;
  logic [rcsu_pkg::SIZE_BITS-1:0]          a_w_q, a_h_q, b_w_q, b_h_q;
  rcsu_pkg::ext_t                          ax, ay, aw, ah, ar, ab;
  rcsu_pkg::ext_t                          bx, by, bw, bh, br, bb;
  logic                                    a_empty, a_null, b_empty, b_null, overlap;
  logic                                    ax_lt_bx, ay_lt_by, ar_gt_br, ab_gt_bb;
  rcsu_pkg::kind_e                         kind;
  logic [rcsu_pkg::NUM_PIECES-1:0]         mask;

  assign accept  = push_i && !full_o;
  assign full_o  = valid_q && has_out && q_full_i;
  assign advance = valid_q && !full_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      a_x_q  <= a_x_i;
      a_y_q  <= a_y_i;
      a_w_q  <= a_w_i;
      a_h_q  <= a_h_i;
      b_x_q  <= b_x_i;
      b_y_q  <= b_y_i;
      b_w_q  <= b_w_i;
      b_h_q  <= b_h_i;
    end
  end

  // Exact edges; right and bottom are held one past the last pixel.
  assign ax = {{CoordExt{a_x_q[rcsu_pkg::COORD_BITS-1]}}, a_x_q};
  assign ay = {{CoordExt{a_y_q[rcsu_pkg::COORD_BITS-1]}}, a_y_q};
  assign bx = {{CoordExt{b_x_q[rcsu_pkg::COORD_BITS-1]}}, b_x_q};
  assign by = {{CoordExt{b_y_q[rcsu_pkg::COORD_BITS-1]}}, b_y_q};
  assign aw = {{SizeExt{1'b0}}, a_w_q};
  assign ah = {{SizeExt{1'b0}}, a_h_q};
  assign bw = {{SizeExt{1'b0}}, b_w_q};
  assign bh = {{SizeExt{1'b0}}, b_h_q};
  assign ar = ax + aw;
  assign ab = ay + ah;
  assign br = bx + bw;
  assign bb = by + bh;

  assign a_empty  = (a_w_q == '0) || (a_h_q == '0);
  assign a_null   = (a_w_q == '0) && (a_h_q == '0);
  assign b_empty  = (b_w_q == '0) || (b_h_q == '0);
  assign b_null   = (b_w_q == '0) && (b_h_q == '0);
  assign ax_lt_bx = ax < bx;
  assign ay_lt_by = ay < by;
  assign ar_gt_br = ar > br;
  assign ab_gt_bb = ab > bb;
  assign overlap  = !a_empty && !b_empty && (ax < br) && (bx < ar) && (ay < bb) && (by < ab);

  always_comb begin
    kind = rcsu_pkg::KIND_PASS_A;
    mask = '0;
    mask[rcsu_pkg::PIECE_TOP] = 1'b1;
    unique case (func_q)
      rcsu_pkg::FUNC_INTERSECT: begin
        kind = overlap ? rcsu_pkg::KIND_INTER : rcsu_pkg::KIND_ZERO;
      end
      rcsu_pkg::FUNC_UNITE: begin
        if (a_null) begin
          kind = rcsu_pkg::KIND_PASS_B;
        end else if (b_null) begin
          kind = rcsu_pkg::KIND_PASS_A;
        end else begin
          kind = rcsu_pkg::KIND_UNITE;
        end
      end
      rcsu_pkg::FUNC_SUBTRACT: begin
        if (a_empty) begin
          mask = '0;
        end else if (overlap) begin
          kind = rcsu_pkg::KIND_SUB;
          mask[rcsu_pkg::PIECE_TOP]    = ay_lt_by;
          mask[rcsu_pkg::PIECE_BOTTOM] = ab_gt_bb;
          mask[rcsu_pkg::PIECE_LEFT]   = ax_lt_bx;
          mask[rcsu_pkg::PIECE_RIGHT]  = ar_gt_br;
        end
      end
      rcsu_pkg::FUNC_CONSTRAIN: begin
        kind = rcsu_pkg::KIND_CONSTR;
      end
      default: begin
        kind = rcsu_pkg::KIND_PASS_A;
      end
    endcase
  end

  assign has_out  = |mask;
  assign q_push_o = valid_q && has_out && !q_full_i;

  always_comb begin
    q_job_o.kind     = kind;
    q_job_o.mask     = mask;
    q_job_o.ax_lt_bx = ax_lt_bx;
    q_job_o.ay_lt_by = ay_lt_by;
    q_job_o.ar_gt_br = ar_gt_br;
    q_job_o.ab_gt_bb = ab_gt_bb;
    q_job_o.ax       = ax;
    q_job_o.ay       = ay;
    q_job_o.aw       = aw;
    q_job_o.ah       = ah;
    q_job_o.ar       = ar;
    q_job_o.ab       = ab;
    q_job_o.bx       = bx;
    q_job_o.by       = by;
    q_job_o.bw       = bw;
    q_job_o.bh       = bh;
    q_job_o.br       = br;
    q_job_o.bb       = bb;
  end

endmodule
`default_nettype wire

// ===== rtl/rcsu_queue.sv =====
`default_nettype none
module rcsu_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                full_o,
  input  wire rcsu_pkg::job_t wr_job_i,
  output logic                rd_valid_o,
  input  wire logic           rd_pop_i,
  output rcsu_pkg::job_t      rd_job_o
);

  localparam int unsigned CntBits = rcsu_pkg::QPTR_BITS + 1;

  rcsu_pkg::job_t                   mem_q [rcsu_pkg::QUEUE_DEPTH];
  logic [rcsu_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]               count_q, count_d;
  logic                             do_wr, do_rd;

  assign full_o     = count_q == CntBits'(rcsu_pkg::QUEUE_DEPTH);
  assign rd_valid_o = count_q != '0;
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + CntBits'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + rcsu_pkg::QPTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + rcsu_pkg::QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcsu_back.sv =====
`default_nettype none
module rcsu_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 head_valid_i,
  input  wire rcsu_pkg::job_t                       head_job_i,
  output logic                                      head_pop_o,
  output logic                                      empty_o,
  input  wire logic                                 pop_i,
  output logic signed [rcsu_pkg::COORD_BITS-1:0]    r_x_o,
  output logic signed [rcsu_pkg::COORD_BITS-1:0]    r_y_o,
  output logic [rcsu_pkg::COORD_BITS-1:0]           r_w_o,
  output logic [rcsu_pkg::COORD_BITS-1:0]           r_h_o,
  output logic                                      last_o
);

  logic                              out_valid_q;
  logic [rcsu_pkg::NUM_PIECES-1:0]   done_q, rem, sel_bit;
  logic                              step, is_last;
  rcsu_pkg::piece_e                  piece;
  rcsu_pkg::ext_t                    x, y, wp, wq, hp, hq, w, h;
  rcsu_pkg::ext_t                    band_top, band_bot, cx, cy;

  assign empty_o = !out_valid_q;
  assign step    = head_valid_i && (!out_valid_q || pop_i);
  assign rem     = head_job_i.mask & ~done_q;

  // Lowest outstanding piece goes first.
  always_comb begin
    if (rem[rcsu_pkg::PIECE_TOP]) begin
      piece = rcsu_pkg::PIECE_TOP;
    end else if (rem[rcsu_pkg::PIECE_BOTTOM]) begin
      piece = rcsu_pkg::PIECE_BOTTOM;
    end else if (rem[rcsu_pkg::PIECE_LEFT]) begin
      piece = rcsu_pkg::PIECE_LEFT;
    end else begin
      piece = rcsu_pkg::PIECE_RIGHT;
    end
  end

  always_comb begin
    sel_bit        = '0;
    sel_bit[piece] = 1'b1;
  end

  assign is_last    = (rem & ~sel_bit) == '0;
  assign head_pop_o = step && is_last;

  assign band_top = head_job_i.ay_lt_by ? head_job_i.by : head_job_i.ay;
  assign band_bot = head_job_i.ab_gt_bb ? head_job_i.bb : head_job_i.ab;

  // Constrain: a move to the right wins over a move to the left.
  assign cx = head_job_i.ax_lt_bx ? head_job_i.bx :
              head_job_i.ar_gt_br ? (head_job_i.br - head_job_i.aw) : head_job_i.ax;
  assign cy = head_job_i.ay_lt_by ? head_job_i.by :
              head_job_i.ab_gt_bb ? (head_job_i.bb - head_job_i.ah) : head_job_i.ay;

  always_comb begin
    x  = head_job_i.ax;
    y  = head_job_i.ay;
    wp = head_job_i.aw;
    wq = '0;
    hp = head_job_i.ah;
    hq = '0;
    unique case (head_job_i.kind)
      rcsu_pkg::KIND_ZERO: begin
        x  = '0;
        y  = '0;
        wp = '0;
        hp = '0;
      end
      rcsu_pkg::KIND_INTER: begin
        x  = head_job_i.ax_lt_bx ? head_job_i.bx : head_job_i.ax;
        y  = head_job_i.ay_lt_by ? head_job_i.by : head_job_i.ay;
        wp = head_job_i.ar_gt_br ? head_job_i.br : head_job_i.ar;
        hp = head_job_i.ab_gt_bb ? head_job_i.bb : head_job_i.ab;
        wq = x;
        hq = y;
      end
      rcsu_pkg::KIND_UNITE: begin
        x  = head_job_i.ax_lt_bx ? head_job_i.ax : head_job_i.bx;
        y  = head_job_i.ay_lt_by ? head_job_i.ay : head_job_i.by;
        wp = head_job_i.ar_gt_br ? head_job_i.ar : head_job_i.br;
        hp = head_job_i.ab_gt_bb ? head_job_i.ab : head_job_i.bb;
        wq = x;
        hq = y;
      end
      rcsu_pkg::KIND_CONSTR: begin
        x = cx;
        y = cy;
      end
      rcsu_pkg::KIND_PASS_A: begin
        x = head_job_i.ax;
      end
      rcsu_pkg::KIND_PASS_B: begin
        x  = head_job_i.bx;
        y  = head_job_i.by;
        wp = head_job_i.bw;
        hp = head_job_i.bh;
      end
      rcsu_pkg::KIND_SUB: begin
        unique case (piece)
          rcsu_pkg::PIECE_TOP: begin
            hp = head_job_i.by;
            hq = head_job_i.ay;
          end
          rcsu_pkg::PIECE_BOTTOM: begin
            y  = head_job_i.bb;
            hp = head_job_i.ab;
            hq = head_job_i.bb;
          end
          rcsu_pkg::PIECE_LEFT: begin
            y  = band_top;
            wp = head_job_i.bx;
            wq = head_job_i.ax;
            hp = band_bot;
            hq = band_top;
          end
          rcsu_pkg::PIECE_RIGHT: begin
            x  = head_job_i.br;
            y  = band_top;
            wp = head_job_i.ar;
            wq = head_job_i.br;
            hp = band_bot;
            hq = band_top;
          end
          default: begin
            hq = '0;
          end
        endcase
      end
      default: begin
        x = head_job_i.ax;
      end
    endcase
  end

  assign w = wp - wq;
  assign h = hp - hq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        done_q      <= is_last ? '0 : (done_q | sel_bit);
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      r_x_o  <= x[rcsu_pkg::COORD_BITS-1:0];
      r_y_o  <= y[rcsu_pkg::COORD_BITS-1:0];
      r_w_o  <= w[rcsu_pkg::COORD_BITS-1:0];
      r_h_o  <= h[rcsu_pkg::COORD_BITS-1:0];
      last_o <= is_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rectangle_clip_subtract_unit_core.sv =====
// Channel   Handshake                Payload
// input     push in, full out        func_i, a_x_i, a_y_i, a_w_i, a_h_i, b_x_i, b_y_i,
//                                    b_w_i, b_h_i
// result    empty out, pop in        r_x_o, r_y_o, r_w_o, r_h_o, last_o
//
// An item passes from the front register through the queue to the result register.
// Intersect, unite and constrain sustain one item per cycle while results are popped;
// a subtract item holds the result register for each piece it produces, from none to four.
// Reset clears only control state; nothing else needs clearing.
// Either side may stall on its own: the four-entry queue between front and back absorbs it.
`default_nettype none
module rectangle_clip_subtract_unit_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [1:0]                           func_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] a_x_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] a_y_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       a_w_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       a_h_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] b_x_i,
  input  wire logic signed [rcsu_pkg::COORD_BITS-1:0] b_y_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       b_w_i,
  input  wire logic [rcsu_pkg::SIZE_BITS-1:0]       b_h_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [rcsu_pkg::COORD_BITS-1:0]    r_x_o,
  output logic signed [rcsu_pkg::COORD_BITS-1:0]    r_y_o,
  output logic [rcsu_pkg::COORD_BITS-1:0]           r_w_o,
  output logic [rcsu_pkg::COORD_BITS-1:0]           r_h_o,
  output logic                                      last_o
);

  // Front to queue: the classified item with its exact edges and compare results.
  logic           q_push, q_full;
  rcsu_pkg::job_t q_wr_job;

  // Queue to back: the oldest classified item, retired once its final result is built.
  logic           head_valid, head_pop;
  rcsu_pkg::job_t head_job;

  // The front registers each item, works out the edges and decides which results it
  // yields. A subtract item that leaves nothing (A empty or wholly covered by B) is
  // dropped here and never enters the queue.
  rcsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .func_i    (func_i),
    .a_x_i     (a_x_i),
    .a_y_i     (a_y_i),
    .a_w_i     (a_w_i),
    .a_h_i     (a_h_i),
    .b_x_i     (b_x_i),
    .b_y_i     (b_y_i),
    .b_w_i     (b_w_i),
    .b_h_i     (b_h_i),
    .q_push_o  (q_push),
    .q_full_i  (q_full),
    .q_job_o   (q_wr_job)
  );

  // The queue lets the front keep taking items while the back emits subtract pieces.
  rcsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (q_push),
    .full_o     (q_full),
    .wr_job_i   (q_wr_job),
    .rd_valid_o (head_valid),
    .rd_pop_i   (head_pop),
    .rd_job_o   (head_job)
  );

  // The back builds one result rectangle per cycle from the head item and holds it in
  // the result register until it is taken; the last flag marks the item's final result.
  rcsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .r_x_o        (r_x_o),
    .r_y_o        (r_y_o),
    .r_w_o        (r_w_o),
    .r_h_o        (r_h_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

// ===== verif/rcsu_checker.sv =====
`timescale 1ns / 1ps
module rcsu_checker
  import rcsu_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  input  wire logic                          full,
  input  wire logic [1:0]                    func_i,
  input  wire logic signed [COORD_BITS-1:0]  a_x_i,
  input  wire logic signed [COORD_BITS-1:0]  a_y_i,
  input  wire logic [SIZE_BITS-1:0]          a_w_i,
  input  wire logic [SIZE_BITS-1:0]          a_h_i,
  input  wire logic signed [COORD_BITS-1:0]  b_x_i,
  input  wire logic signed [COORD_BITS-1:0]  b_y_i,
  input  wire logic [SIZE_BITS-1:0]          b_w_i,
  input  wire logic [SIZE_BITS-1:0]          b_h_i,
  input  wire logic                          empty,
  input  wire logic                          pop,
  input  wire logic signed [COORD_BITS-1:0]  r_x_o,
  input  wire logic signed [COORD_BITS-1:0]  r_y_o,
  input  wire logic [COORD_BITS-1:0]         r_w_o,
  input  wire logic [COORD_BITS-1:0]         r_h_o,
  input  wire logic                          last_o,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);

  // Rectangles are held at full precision and only wrapped when a result is formed.
  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
  } box_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic                  last;
  } rect_out_t;

  localparam int REPORT_LIMIT = 50;

  rect_out_t expected_rects[$];
  int        mismatches   = 0;
  int        results_seen = 0;

  function automatic longint right_edge(box_t r);
    return r.x + r.w - 1;
  endfunction

  function automatic longint bottom_edge(box_t r);
    return r.y + r.h - 1;
  endfunction

  function automatic void queue_rect(box_t r, bit last);
    rect_out_t o;
    longint    vx, vy, vw, vh;
    vx     = r.x;
    vy     = r.y;
    vw     = r.w;
    vh     = r.h;
    o.x    = vx[COORD_BITS-1:0];
    o.y    = vy[COORD_BITS-1:0];
    o.w    = vw[COORD_BITS-1:0];
    o.h    = vh[COORD_BITS-1:0];
    o.last = last;
    expected_rects.push_back(o);
  endfunction

  // Works out every result that one rectangle pair causes, in the order they leave.
  function automatic void predict_rect_op(logic [1:0] op, box_t a, box_t b);
    box_t   r;
    box_t   piece [4];
    longint lft, rgt, top, bot, dx, dy, band_top, band_bot;
    int     count, n;
    bit     disjoint;
    case (op)
      FUNC_INTERSECT: begin
        lft = (a.x > b.x) ? a.x : b.x;
        rgt = (right_edge(a) < right_edge(b)) ? right_edge(a) : right_edge(b);
        top = (a.y > b.y) ? a.y : b.y;
        bot = (bottom_edge(a) < bottom_edge(b)) ? bottom_edge(a) : bottom_edge(b);
        r   = '{0, 0, 0, 0};
        if (lft <= rgt && top <= bot) begin
          r = '{lft, top, rgt - lft + 1, bot - top + 1};
        end
        queue_rect(r, 1'b1);
      end
      FUNC_UNITE: begin
        if (a.w == 0 && a.h == 0) begin
          r = b;
        end else if (b.w == 0 && b.h == 0) begin
          r = a;
        end else begin
          r.x = (a.x < b.x) ? a.x : b.x;
          r.y = (a.y < b.y) ? a.y : b.y;
          rgt = (right_edge(a) > right_edge(b)) ? right_edge(a) : right_edge(b);
          bot = (bottom_edge(a) > bottom_edge(b)) ? bottom_edge(a) : bottom_edge(b);
          r.w = rgt - r.x + 1;
          r.h = bot - r.y + 1;
        end
        queue_rect(r, 1'b1);
      end
      FUNC_SUBTRACT: begin
        disjoint = (b.w == 0) || (b.h == 0) ||
                   (a.x > right_edge(b)) || (b.x > right_edge(a)) ||
                   (a.y > bottom_edge(b)) || (b.y > bottom_edge(a));
        if (a.w == 0 || a.h == 0) begin
          // An empty A leaves nothing behind.
        end else if (disjoint) begin
          queue_rect(a, 1'b1);
        end else begin
          band_top = (b.y > a.y) ? b.y : a.y;
          band_bot = (b.y + b.h < a.y + a.h) ? b.y + b.h : a.y + a.h;
          piece[0] = '{a.x, a.y, a.w, b.y - a.y};
          piece[1] = '{a.x, b.y + b.h, a.w, (a.y + a.h) - (b.y + b.h)};
          piece[2] = '{a.x, band_top, b.x - a.x, band_bot - band_top};
          piece[3] = '{b.x + b.w, band_top, (a.x + a.w) - (b.x + b.w), band_bot - band_top};
          count = 0;
          for (int i = 0; i < 4; i++) begin
            if (piece[i].w > 0 && piece[i].h > 0) count++;
          end
          n = 0;
          for (int i = 0; i < 4; i++) begin
            if (piece[i].w > 0 && piece[i].h > 0) begin
              queue_rect(piece[i], n == count - 1);
              n++;
            end
          end
        end
      end
      default: begin
        dx = 0;
        dy = 0;
        if (right_edge(a) > right_edge(b)) dx = right_edge(b) - right_edge(a);
        if (bottom_edge(a) > bottom_edge(b)) dy = bottom_edge(b) - bottom_edge(a);
        if (a.x < b.x) dx = b.x - a.x;
        if (a.y < b.y) dy = b.y - a.y;
        r   = a;
        r.x = a.x + dx;
        r.y = a.y + dy;
        queue_rect(r, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : watch
    box_t      a, b;
    rect_out_t got, want;
    if (rst_ni) begin
      // New expectations first, so a result is always checked against the oldest one.
      if (push && !full) begin
        a = '{longint'(a_x_i), longint'(a_y_i), longint'(a_w_i), longint'(a_h_i)};
        b = '{longint'(b_x_i), longint'(b_y_i), longint'(b_w_i), longint'(b_h_i)};
        predict_rect_op(func_i, a, b);
      end
      if (pop && !empty) begin
        got = '{r_x_o, r_y_o, r_w_o, r_h_o, last_o};
        results_seen++;
        if (expected_rects.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected result x=%0d y=%0d w=%0d h=%0d last=%0b", $time,
                     $signed(got.x), $signed(got.y), got.w, got.h, got.last);
          end
        end else begin
          want = expected_rects.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
              got.h !== want.h || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: expected x=%0d y=%0d w=%0d h=%0d last=%0b, ",
                       $time, $signed(want.x), $signed(want.y), want.w, want.h, want.last,
                       "got x=%0d y=%0d w=%0d h=%0d last=%0b",
                       $signed(got.x), $signed(got.y), got.w, got.h, got.last);
            end
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_rects.size();
    checked_o    <= results_seen;
  end

endmodule

// ===== verif/rectangle_clip_subtract_unit_core_tb.sv =====
`timescale 1ns / 1ps
module rectangle_clip_subtract_unit_core_tb;
  import rcsu_pkg::*;

  // Number of random rectangle pairs after the directed part.
  localparam int RANDOM_ITEMS = 430;
  // Cycles without any accepted item or result before the run is abandoned. The slowest
  // correct gap is a sender burst plus a receiver burst plus the pipeline, well under this.
  localparam int IDLE_LIMIT   = 2000;
  // Cycles allowed after the last expected result for stray results to appear.
  localparam int DRAIN_CYCLES = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Input channel. Every input starts at a known value before the first edge.
  logic                         push   = 1'b0;
  logic                         full;
  logic [1:0]                   func_i = FUNC_INTERSECT;
  logic signed [COORD_BITS-1:0] a_x_i  = '0;
  logic signed [COORD_BITS-1:0] a_y_i  = '0;
  logic [SIZE_BITS-1:0]         a_w_i  = '0;
  logic [SIZE_BITS-1:0]         a_h_i  = '0;
  logic signed [COORD_BITS-1:0] b_x_i  = '0;
  logic signed [COORD_BITS-1:0] b_y_i  = '0;
  logic [SIZE_BITS-1:0]         b_w_i  = '0;
  logic [SIZE_BITS-1:0]         b_h_i  = '0;

  // Result channel.
  logic                         empty;
  logic                         pop    = 1'b0;
  logic signed [COORD_BITS-1:0] r_x_o;
  logic signed [COORD_BITS-1:0] r_y_o;
  logic [COORD_BITS-1:0]        r_w_o;
  logic [COORD_BITS-1:0]        r_h_o;
  logic                         last_o;

  int fail_count;
  int pending_results;
  int checked_results;

  // When calm is set, neither side idles: both run flat out.
  bit calm = 1'b0;
  int stall_left = 0;
  int op_count [4] = '{0, 0, 0, 0};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  rectangle_clip_subtract_unit_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .func_i (func_i),
    .a_x_i  (a_x_i),
    .a_y_i  (a_y_i),
    .a_w_i  (a_w_i),
    .a_h_i  (a_h_i),
    .b_x_i  (b_x_i),
    .b_y_i  (b_y_i),
    .b_w_i  (b_w_i),
    .b_h_i  (b_h_i),
    .empty  (empty),
    .pop    (pop),
    .r_x_o  (r_x_o),
    .r_y_o  (r_y_o),
    .r_w_o  (r_w_o),
    .r_h_o  (r_h_o),
    .last_o (last_o)
  );

  // The checker sits beside the block, predicts every result and tallies the failures.
  rcsu_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .a_w_i        (a_w_i),
    .a_h_i        (a_h_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .b_w_i        (b_w_i),
    .b_h_i        (b_h_i),
    .empty        (empty),
    .pop          (pop),
    .r_x_o        (r_x_o),
    .r_y_o        (r_y_o),
    .r_w_o        (r_w_o),
    .r_h_o        (r_h_o),
    .last_o       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (checked_results)
  );

  // The receiver pops whenever it can, but outside the calm stretches it now and then
  // stalls for a burst of random length, so that the result queue backs up and the
  // sender sees full.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      pop <= 1'b1;
    end
  end

  // Offers one rectangle pair and returns at the edge where it is accepted. Push is left
  // high so that the next item can follow without a gap; a gap, when one is wanted, is
  // made at the start of the next call, so push is never lowered and raised in one step.
  task automatic send_pair(input logic [1:0] op,
                           input logic signed [COORD_BITS-1:0] ax, ay,
                           input logic [SIZE_BITS-1:0] aw, ah,
                           input logic signed [COORD_BITS-1:0] bx, by,
                           input logic [SIZE_BITS-1:0] bw, bh);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    func_i <= op;
    a_x_i  <= ax;
    a_y_i  <= ay;
    a_w_i  <= aw;
    a_h_i  <= ah;
    b_x_i  <= bx;
    b_y_i  <= by;
    b_w_i  <= bw;
    b_h_i  <= bh;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    op_count[op]++;
  endtask

  // Most pairs sit close together in a small window so that they overlap in every way;
  // some sit at the corners of the coordinate range so that edges wrap, and some take
  // every field at random over its whole width.
  task automatic send_random_pair();
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic [SIZE_BITS-1:0]         aw, ah, bw, bh;
    int                           mode, pick, ox, oy, tx, ty, ux, uy;
    mode = $urandom_range(0, 9);
    pick = $urandom_range(0, 4);
    case (pick)
      0:       op = FUNC_INTERSECT;
      1:       op = FUNC_UNITE;
      2:       op = FUNC_CONSTRAIN;
      default: op = FUNC_SUBTRACT;
    endcase
    if (mode < 2) begin
      ax = COORD_BITS'($urandom);
      ay = COORD_BITS'($urandom);
      aw = SIZE_BITS'($urandom);
      ah = SIZE_BITS'($urandom);
      bx = COORD_BITS'($urandom);
      by = COORD_BITS'($urandom);
      bw = SIZE_BITS'($urandom);
      bh = SIZE_BITS'($urandom);
    end else begin
      ox = (mode == 2) ? 32700 : (mode == 3) ? -32768 : 0;
      oy = (mode == 2) ? -32768 : (mode == 3) ? 32700 : 0;
      tx = ox + $urandom_range(0, 64);
      ty = oy + $urandom_range(0, 64);
      aw = SIZE_BITS'($urandom_range(1, 40));
      ah = SIZE_BITS'($urandom_range(1, 40));
      if ($urandom_range(0, 9) == 0) aw = '0;
      if ($urandom_range(0, 9) == 0) ah = '0;
      if ($urandom_range(0, 7) == 0) begin
        // B swallows A whole, so a subtract leaves nothing, unless B wraps past the edge of the range.
        ux = tx - $urandom_range(0, 3);
        uy = ty - $urandom_range(0, 3);
        bw = SIZE_BITS'(aw + $urandom_range(3, 9));
        bh = SIZE_BITS'(ah + $urandom_range(3, 9));
      end else begin
        ux = tx + $urandom_range(0, 50) - 20;
        uy = ty + $urandom_range(0, 50) - 20;
        bw = SIZE_BITS'($urandom_range(0, 40));
        bh = SIZE_BITS'($urandom_range(0, 40));
      end
      ax = tx[COORD_BITS-1:0];
      ay = ty[COORD_BITS-1:0];
      bx = ux[COORD_BITS-1:0];
      by = uy[COORD_BITS-1:0];
    end
    send_pair(op, ax, ay, aw, ah, bx, by, bw, bh);
  endtask

  // Watchdog: a run in which nothing moves for too long has hung.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timed out after %0d cycles without progress.", IDLE_LIMIT);
    $display("rectangle_clip_subtract_unit_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Intersect: a plain overlap, two rectangles that only touch, an empty
    // operand, two far corners of the coordinate range, and an overlap whose right and
    // bottom edges lie past the top of the range.
    send_pair(FUNC_INTERSECT, 10, 20, 30, 40, 25, 30, 50, 10);
    send_pair(FUNC_INTERSECT, 0, 0, 10, 10, 10, 0, 5, 5);
    send_pair(FUNC_INTERSECT, 0, 0, 0, 10, 0, 0, 5, 5);
    send_pair(FUNC_INTERSECT, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(FUNC_INTERSECT, 32767, 32767, 32767, 32767, 32000, 32000, 32767, 32767);

    // Unite: a plain bounding box, each operand null, both null, an operand with only one
    // zero side, and a box spanning the whole range so that its width wraps.
    send_pair(FUNC_UNITE, 0, 0, 10, 10, -5, 20, 3, 3);
    send_pair(FUNC_UNITE, 100, 100, 0, 0, 1, 2, 3, 4);
    send_pair(FUNC_UNITE, 1, 2, 3, 4, 100, 100, 0, 0);
    send_pair(FUNC_UNITE, 7, 8, 0, 0, -9, -10, 0, 0);
    send_pair(FUNC_UNITE, 0, 0, 0, 10, 5, 5, 5, 5);
    send_pair(FUNC_UNITE, -32768, -32768, 1, 1, 32767, 32767, 32767, 32767);

    // Subtract: disjoint, empty B, empty A, A fully covered, B inside A (four pieces),
    // B over one corner, B as a band straight across, and A at the bottom of the range.
    send_pair(FUNC_SUBTRACT, 0, 0, 10, 10, 50, 50, 5, 5);
    send_pair(FUNC_SUBTRACT, 0, 0, 10, 10, 2, 2, 0, 5);
    send_pair(FUNC_SUBTRACT, 0, 0, 10, 0, 2, 2, 5, 5);
    send_pair(FUNC_SUBTRACT, 5, 5, 4, 4, 0, 0, 20, 20);
    send_pair(FUNC_SUBTRACT, 0, 0, 10, 10, 3, 3, 4, 4);
    send_pair(FUNC_SUBTRACT, 0, 0, 10, 10, -5, -5, 10, 10);
    send_pair(FUNC_SUBTRACT, 0, 0, 10, 10, -5, 4, 30, 2);
    send_pair(FUNC_SUBTRACT, -32768, -32768, 32767, 32767, -100, -100, 200, 200);

    // Constrain: already inside, past the right edge, wider than B so the left rule wins,
    // an empty B, and shifts between the corners of the range.
    send_pair(FUNC_CONSTRAIN, 2, 2, 5, 5, 0, 0, 20, 20);
    send_pair(FUNC_CONSTRAIN, 15, 18, 10, 5, 0, 0, 20, 20);
    send_pair(FUNC_CONSTRAIN, -5, -5, 30, 30, 0, 0, 20, 20);
    send_pair(FUNC_CONSTRAIN, 5, 5, 3, 3, 100, 100, 0, 0);
    send_pair(FUNC_CONSTRAIN, 32767, -32768, 32767, 32767, -32768, 32767, 1, 1);

    // Random part: idling on both sides, then a stretch flat out, idling again, and a
    // final stretch with no idling at all.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) calm <= 1'b1;
      if (i == 280) calm <= 1'b0;
      if (i == 380) calm <= 1'b1;
      send_random_pair();
    end
    push <= 1'b0;

    // Wait for every expected result, then give stray results time to show up.
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d rectangle pairs: %0d intersect, %0d unite, %0d subtract, %0d constrain.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[FUNC_INTERSECT], op_count[FUNC_UNITE],
             op_count[FUNC_SUBTRACT], op_count[FUNC_CONSTRAIN]);
    $display("Checked %0d result rectangles; %0d failures, %0d still outstanding.",
             checked_results, fail_count, pending_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("rectangle_clip_subtract_unit_core_tb passed");
    end else begin
      $display("rectangle_clip_subtract_unit_core_tb failed");
    end
    $finish;
  end

endmodule
